// ===== hw/rtl/modular_exponentiation_defines.svh =====
// assertion macros shared by the modular exponentiation rtl
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define MODEXP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("modexp assertion failed");
// condition must never be true out of reset
`define MODEXP_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("modexp forbidden condition seen");
`else
`define MODEXP_ASSERT(label, clk, rst_n, prop)
`define MODEXP_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/modexp_pkg.sv =====
// package with widths, reset values and state codes of the modular exponentiation block
package modexp_pkg;

    // field widths of the stream beats
    localparam int BASE_WIDTH      = 32;
    localparam int EXP_FIELD_WIDTH = 63;
    localparam int RESULT_WIDTH    = 32;
    localparam int EXP_LSB         = BASE_WIDTH;
    localparam int S_TDATA_WIDTH   = 96;
    localparam int M_TDATA_WIDTH   = 32;

    // parameter defaults
    localparam int DEF_EXP_WIDTH = 63;
    localparam int DEF_MOD_WIDTH = 32;

    // modulus after reset
    localparam logic [31:0] RESET_MODULUS = 32'd1000000007;

    // control states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PRE  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

endpackage

// ===== hw/rtl/modular_exponentiation.sv =====
// modular exponentiation: base to the exponent modulo a configured modulus
//
// input stream (s_axis): one beat carries base_value and exponent; the
// block takes a beat only when it holds no item in work (tready high).
// output stream (m_axis): one beat carries result_value for each input beat.
// configuration: i_cfg_we writes i_cfg_wdata into the modulus register;
// write it only while no item is in work. a modulus of zero acts as
// 2^MOD_WIDTH. reset sets the modulus to 1000000007.
// the exponent is scanned lsb first. two bit-serial multipliers run side by
// side, each taking one multiplier bit per cycle for a modular product:
// one updates the accumulator, the other squares the running base. the base
// is first reduced by one pass of the squaring unit.
// one item is in work at a time, and the block is ready for the next beat
// in the same cycle that the result appears.
// the result sits in an output register; a stalled receiver holds it there
// while the next item is already accepted and computed.
`include "modular_exponentiation_defines.svh"

module modular_exponentiation #(
    parameter int EXP_WIDTH = modexp_pkg::DEF_EXP_WIDTH,
    parameter int MOD_WIDTH = modexp_pkg::DEF_MOD_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write
    input  logic                                 i_cfg_we,
    input  logic [MOD_WIDTH-1:0]                 i_cfg_wdata,
    // input stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: base_value [31:0], exponent [94:32], zero [95]
    input  logic [modexp_pkg::S_TDATA_WIDTH-1:0] i_s_axis_tdata,
    // output stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // tdata: result_value [31:0]
    output logic [modexp_pkg::M_TDATA_WIDTH-1:0] o_m_axis_tdata
);
    import modexp_pkg::*;

    t_state                  r_state, n_state;
    logic [MOD_WIDTH-1:0]    r_modulus;
    logic [EXP_WIDTH-1:0]    r_exp, n_exp;
    logic [MOD_WIDTH-1:0]    r_acc, n_acc;
    logic                    r_out_valid, n_out_valid;
    logic [RESULT_WIDTH-1:0] r_out_data;

    logic                    w_accept;
    logic [MOD_WIDTH:0]      w_modulus;
    logic [MOD_WIDTH-1:0]    w_one;
    logic [EXP_WIDTH-1:0]    w_exp_shift;

    logic                    w_sq_start, w_acc_start;
    logic [BASE_WIDTH-1:0]   w_sq_mult, w_acc_mult;
    logic [MOD_WIDTH-1:0]    w_sq_mcand;
    logic                    w_sq_done, w_acc_done;
    logic [MOD_WIDTH-1:0]    w_sq_product, w_acc_product;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // effective modulus, zero meaning 2^MOD_WIDTH, and 1 reduced by it
    assign w_modulus   = (r_modulus == '0) ? {1'b1, {MOD_WIDTH{1'b0}}} : {1'b0, r_modulus};
    assign w_one       = (w_modulus == (MOD_WIDTH + 1)'(1)) ? '0 : MOD_WIDTH'(1);
    assign w_exp_shift = r_exp >> 1;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        w_sq_start  = 1'b0;
        w_acc_start = 1'b0;
        w_sq_mult   = 32'(w_sq_product);
        w_sq_mcand  = w_sq_product;
        w_acc_mult  = 32'(r_acc);

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                // reduce the base: base * 1 mod m
                if (w_accept) begin
                    n_exp      = EXP_WIDTH'(i_s_axis_tdata[EXP_LSB +: EXP_FIELD_WIDTH]);
                    n_acc      = MOD_WIDTH'(1);
                    w_sq_start = 1'b1;
                    w_sq_mult  = i_s_axis_tdata[BASE_WIDTH-1:0];
                    w_sq_mcand = w_one;
                    n_state    = ST_PRE;
                end
            end
            ST_PRE: begin
                if (w_sq_done) begin
                    if (r_exp == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        w_sq_start  = 1'b1;
                        w_acc_start = 1'b1;
                        n_state     = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                // one exponent bit retired per product pair
                if (w_sq_done) begin
                    if (r_exp[0]) begin
                        n_acc = w_acc_product;
                    end
                    n_exp      = w_exp_shift;
                    w_acc_mult = 32'(n_acc);
                    if (w_exp_shift == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        w_sq_start  = 1'b1;
                        w_acc_start = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_modulus   <= MOD_WIDTH'(RESET_MODULUS);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_exp <= n_exp;
        r_acc <= n_acc;
        if ((r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready)) begin
            r_out_data <= 32'(r_acc);
        end
    end

    // squaring unit, also reduces the base at the start of an item
    modexp_mulmod #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_sq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_sq_start),
        .i_mult    (w_sq_mult),
        .i_mcand   (w_sq_mcand),
        .i_modulus (w_modulus),
        .o_done    (w_sq_done),
        .o_product (w_sq_product)
    );

    // accumulator unit
    modexp_mulmod #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_acc_start),
        .i_mult    (w_acc_mult),
        .i_mcand   (w_sq_product),
        .i_modulus (w_modulus),
        .o_done    (w_acc_done),
        .o_product (w_acc_product)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `MODEXP_ASSERT_NEVER(a_idle_no_done, i_clk, i_rst_n, (r_state == ST_IDLE) && (w_sq_done || w_acc_done))
    `MODEXP_ASSERT(a_units_in_step, i_clk, i_rst_n, (r_state == ST_MUL) |-> (w_acc_done == w_sq_done))
    `MODEXP_ASSERT(a_accept_to_pre, i_clk, i_rst_n, w_accept |=> (r_state == ST_PRE))

endmodule

// ===== hw/rtl/modexp_mulmod.sv =====
// bit-serial interleaved modular multiplier, one multiplier bit per cycle msb first
`include "modular_exponentiation_defines.svh"

module modexp_mulmod #(
    parameter int MOD_WIDTH = modexp_pkg::DEF_MOD_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [modexp_pkg::BASE_WIDTH-1:0] i_mult,
    input  logic [MOD_WIDTH-1:0]              i_mcand,
    input  logic [MOD_WIDTH:0]                i_modulus,
    output logic                              o_done,
    output logic [MOD_WIDTH-1:0]              o_product
);
    import modexp_pkg::*;

    localparam int SUM_WIDTH = MOD_WIDTH + 2;
    localparam int CNT_WIDTH = $clog2(BASE_WIDTH);
    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(BASE_WIDTH - 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_WIDTH-1:0]  r_cnt;
    logic [BASE_WIDTH-1:0] r_a;
    logic [MOD_WIDTH-1:0]  r_b;
    logic [MOD_WIDTH:0]    r_m;
    logic [MOD_WIDTH-1:0]  r_r;

    logic [SUM_WIDTH-1:0]  w_sum;
    logic [SUM_WIDTH-1:0]  w_m_ext;
    logic [SUM_WIDTH-1:0]  w_red1;
    logic [SUM_WIDTH-1:0]  w_red2;

    // one step: r = 2r + bit*b, then at most two subtractions of m
    always_comb begin
        w_m_ext = SUM_WIDTH'(r_m);
        w_sum   = SUM_WIDTH'({r_r, 1'b0}) + (r_a[BASE_WIDTH-1] ? SUM_WIDTH'(r_b) : '0);
        w_red1  = (w_sum >= w_m_ext) ? (w_sum - w_m_ext) : w_sum;
        w_red2  = (w_red1 >= w_m_ext) ? (w_red1 - w_m_ext) : w_red1;
    end

    // control next state
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy && (r_cnt == CNT_LAST)) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // operand shift register and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_mult;
            r_b   <= i_mcand;
            r_m   <= i_modulus;
            r_r   <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_a   <= {r_a[BASE_WIDTH-2:0], 1'b0};
            r_r   <= w_red2[MOD_WIDTH-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_r;

    `MODEXP_ASSERT(a_result_reduced, i_clk, i_rst_n, r_done |-> ({1'b0, r_r} < r_m))
    `MODEXP_ASSERT_NEVER(a_done_while_busy, i_clk, i_rst_n, r_done && r_busy)
    `MODEXP_ASSERT(a_last_step_done, i_clk, i_rst_n, (r_busy && !i_start && (r_cnt == CNT_LAST)) |=> r_done)

endmodule
